### src/ett_pkg.sv
`timescale 1ns / 1ps
package ett_pkg;

  // Field and datapath widths
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int SMP_W            = 32;
  localparam int TPM_W            = 32;
  localparam int MSEC_W           = 31;
  localparam int TICK_W           = 64;
  localparam int CNT_W            = $clog2(TICK_W);

  localparam logic [TPM_W-1:0]  TPM_RST  = 32'd1000;
  localparam logic [MSEC_W-1:0] MSEC_MAX = '1;

  // Command codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_POLL  = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_TPM = 1'b0,
    CFG_HW  = 1'b1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_POLL,
    S_SUB,
    S_DIV,
    S_RESP
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic              done;
    logic [MSEC_W-1:0] quo;
  } div_res_t;

endpackage

### src/ett_div.sv
`timescale 1ns / 1ps
module ett_div import ett_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [TPM_W-1:0]  divisor,
  output div_res_t          res
);

  // Last iteration and last iteration that yields a quotient bit above the msec range
  localparam logic [CNT_W-1:0] LAST_IT = CNT_W'(TICK_W - 1);
  localparam logic [CNT_W-1:0] HIGH_IT = CNT_W'(TICK_W - MSEC_W - 1);

  logic              busy_r;
  logic              done_r;
  logic              sat_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TICK_W-1:0] dvd_r;
  logic [TPM_W-1:0]  rem_r;
  logic [TPM_W-1:0]  dvs_r;
  logic [TPM_W:0]    trial;
  logic [TPM_W:0]    diff;
  logic              q_bit;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_r, dvd_r[TICK_W-1]};
    diff  = trial - {1'b0, dvs_r};
    q_bit = (trial >= {1'b0, dvs_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r && cnt_r == LAST_IT) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits enter the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[TICK_W-2:0], q_bit};
      rem_r <= q_bit ? diff[TPM_W-1:0] : trial[TPM_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
      if (q_bit && cnt_r <= HIGH_IT) begin
        sat_r <= 1'b1;
      end
    end
  end

  // Saturate quotients that do not fit the msec field
  always_comb begin
    res.done = done_r;
    res.quo  = sat_r ? MSEC_MAX : dvd_r[MSEC_W-1:0];
  end

endmodule

### src/elapsed_timeout_timer_unit.sv
`timescale 1ns / 1ps
// Millisecond timeout timer fed by samples of a free-running tick counter.
// Input channel (in_valid/in_ready) carries a command: start (msec, sample),
// poll (sample), query remaining, or an invalid code. Every command yields
// exactly one result on the output channel (out_valid/out_ready): the expiry
// latch, remaining msec for a query, and a bad-opcode flag.
// The cfg_ port writes ticks_per_msec (index 0) and use_hw_sample (index 1);
// write it only while no command is in flight.
// Commands are handled one at a time and all arithmetic is bit serial:
//   start: shift-add multiply.
//   poll: serial add and compare.
//   query: serial subtract plus a 64-step restoring divider.
//   invalid code, poll or query while expired: result without a serial step.
// A finished result sits in the output register; the next command is taken
// while it waits, and a later result holds in its last stage until the
// output register frees up. Reset (synchronous, active low) restores
// ticks_per_msec 1000, hardware sample mode, zero counts and expired set.
module elapsed_timeout_timer_unit import ett_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TPM_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [MSEC_W-1:0] in_msec,
  input  logic [SMP_W-1:0]  in_timer_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_expired,
  output logic [MSEC_W-1:0] out_remaining_msec,
  output logic              out_bad_opcode
);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(TPM_W - 1);
  localparam logic [CNT_W-1:0] SER_LAST = CNT_W'(TICK_W - 1);

  state_t state_r, state_nxt;

  // Architectural state
  logic [TPM_W-1:0]        tpm_r;
  logic                    use_hw_r;
  logic [TICK_W-1:0]       elapsed_r;
  logic [TICK_W-1:0]       timeout_r;
  logic [SAMPLE_WIDTH-1:0] last_sample_r;
  logic                    timed_out_r;

  // Working registers
  logic [CNT_W-1:0]        cnt_r;
  logic [TICK_W-1:0]       sum_sr;
  logic [SAMPLE_WIDTH-1:0] fresh_r;
  logic [SAMPLE_WIDTH-1:0] fsh_r;
  logic [SAMPLE_WIDTH-1:0] lsh_r;
  logic                    c_r;
  logic                    bd_r;
  logic                    cb_r;
  logic                    res_bad_r;
  logic [MSEC_W-1:0]       res_rem_r;

  // Output register
  logic              out_valid_r;
  logic              out_expired_r;
  logic [MSEC_W-1:0] out_rem_r;
  logic              out_bad_r;

  op_t                     op;
  logic                    accept;
  logic                    out_load;
  logic                    div_start;
  logic [SAMPLE_WIDTH-1:0] fresh_nxt;
  logic                    in_rng;
  logic                    e_bit, t_bit, f_bit, l_bit;
  logic                    d_bit, s_bit, q_bit;
  logic                    bd_nxt, c_nxt, cb_nxt, qb_nxt, nz_nxt;
  logic [TPM_W:0]          mul_add;
  logic [TICK_W-1:0]       mul_nxt;
  div_res_t                div_res;

  assign op     = op_t'(in_opcode);
  assign accept = in_valid && in_ready;

  // New sample: the counter value, or last plus one in loop mode (zero for a start)
  always_comb begin
    if (op == OP_START) begin
      fresh_nxt = use_hw_r ? in_timer_sample[SAMPLE_WIDTH-1:0] : '0;
    end else begin
      fresh_nxt = use_hw_r ? in_timer_sample[SAMPLE_WIDTH-1:0]
                           : last_sample_r + SAMPLE_WIDTH'(1);
    end
  end

  // Serial bit slice: sample delta, elapsed sum, compare against timeout
  always_comb begin
    e_bit  = elapsed_r[0];
    t_bit  = timeout_r[0];
    f_bit  = fsh_r[0];
    l_bit  = lsh_r[0];
    in_rng = (int'(cnt_r) < SAMPLE_WIDTH);
    d_bit  = in_rng & (f_bit ^ l_bit ^ bd_r);
    bd_nxt = in_rng ? ((~f_bit & (l_bit | bd_r)) | (l_bit & bd_r)) : bd_r;
    s_bit  = e_bit ^ d_bit ^ c_r;
    c_nxt  = (e_bit & d_bit) | (e_bit & c_r) | (d_bit & c_r);
    cb_nxt = (~s_bit & (t_bit | cb_r)) | (t_bit & cb_r);
    // query: timeout minus elapsed, track borrow and nonzero
    q_bit  = t_bit ^ e_bit ^ c_r;
    qb_nxt = (~t_bit & (e_bit | c_r)) | (e_bit & c_r);
    nz_nxt = cb_r | q_bit;
  end

  // Shift-add multiply step: msec in the low half, product grows from the top
  always_comb begin
    mul_add = {1'b0, sum_sr[TICK_W-1:TPM_W]} + (sum_sr[0] ? {1'b0, tpm_r} : '0);
    mul_nxt = {mul_add, sum_sr[TPM_W-1:1]};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_START: state_nxt = S_MUL;
            OP_POLL:  state_nxt = timed_out_r ? S_RESP : S_POLL;
            OP_QUERY: state_nxt = timed_out_r ? S_RESP : S_SUB;
            default:  state_nxt = S_RESP;
          endcase
        end
      end
      S_MUL: begin
        if (cnt_r == MUL_LAST) state_nxt = S_RESP;
      end
      S_POLL: begin
        if (cnt_r == SER_LAST) state_nxt = S_RESP;
      end
      S_SUB: begin
        if (cnt_r == SER_LAST) state_nxt = (qb_nxt || !nz_nxt) ? S_RESP : S_DIV;
      end
      S_DIV: begin
        if (div_res.done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SUB:  div_start = (cnt_r == SER_LAST) && !qb_nxt && nz_nxt;
      S_RESP: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  ett_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({q_bit, sum_sr[TICK_W-1:1]}),
    .divisor  (tpm_r),
    .res      (div_res)
  );

  // State register, configuration and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tpm_r         <= TPM_RST;
      use_hw_r      <= 1'b1;
      elapsed_r     <= '0;
      timeout_r     <= '0;
      last_sample_r <= '0;
      timed_out_r   <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TPM: tpm_r    <= cfg_wdata;
          CFG_HW:  use_hw_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        S_MUL: begin
          if (cnt_r == MUL_LAST) begin
            timeout_r     <= mul_nxt;
            elapsed_r     <= '0;
            timed_out_r   <= 1'b0;
            last_sample_r <= fresh_r;
          end
        end
        S_POLL: begin
          // rotate; a full turn brings both counts back in place
          timeout_r <= {t_bit, timeout_r[TICK_W-1:1]};
          if (cnt_r == SER_LAST && cb_nxt) begin
            elapsed_r     <= {s_bit, sum_sr[TICK_W-1:1]};
            last_sample_r <= fresh_r;
          end else begin
            elapsed_r <= {e_bit, elapsed_r[TICK_W-1:1]};
          end
          if (cnt_r == SER_LAST && !cb_nxt) begin
            timed_out_r <= 1'b1;
          end
        end
        S_SUB: begin
          elapsed_r <= {e_bit, elapsed_r[TICK_W-1:1]};
          timeout_r <= {t_bit, timeout_r[TICK_W-1:1]};
        end
        default: ;
      endcase
      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_r     <= '0;
          c_r       <= 1'b0;
          bd_r      <= 1'b0;
          cb_r      <= 1'b0;
          res_bad_r <= (op == OP_BAD);
          res_rem_r <= '0;
          fresh_r   <= fresh_nxt;
          fsh_r     <= fresh_nxt;
          lsh_r     <= last_sample_r;
          sum_sr    <= {{(TICK_W - MSEC_W){1'b0}}, in_msec};
        end
      end
      S_MUL: begin
        sum_sr <= mul_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      S_POLL: begin
        sum_sr <= {s_bit, sum_sr[TICK_W-1:1]};
        fsh_r  <= fsh_r >> 1;
        lsh_r  <= lsh_r >> 1;
        c_r    <= c_nxt;
        bd_r   <= bd_nxt;
        cb_r   <= cb_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      S_SUB: begin
        sum_sr <= {q_bit, sum_sr[TICK_W-1:1]};
        c_r    <= qb_nxt;
        cb_r   <= nz_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      S_DIV: begin
        if (div_res.done) res_rem_r <= div_res.quo;
      end
      default: ;
    endcase
    if (out_load) begin
      out_expired_r <= timed_out_r;
      out_rem_r     <= res_rem_r;
      out_bad_r     <= res_bad_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_expired        = out_expired_r;
  assign out_remaining_msec = out_rem_r;
  assign out_bad_opcode     = out_bad_r;

endmodule

### src/ett_chk.sv
`timescale 1ns / 1ps
module ett_chk import ett_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_expired,
  input logic [MSEC_W-1:0] out_remaining_msec,
  input logic              out_bad_opcode
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_expired) &&
      $stable(out_remaining_msec) && $stable(out_bad_opcode))
    else $error("stalled result changed");

  // One command at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // Invalid commands report no remaining time
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_opcode |-> out_remaining_msec == '0)
    else $error("bad opcode with nonzero remaining time");

  // Expired timer reports no remaining time
  a_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired |-> out_remaining_msec == '0)
    else $error("expired with nonzero remaining time");

endmodule

bind elapsed_timeout_timer_unit ett_chk u_ett_chk (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
import ett_pkg::*;

// One result transfer as the block presents it
typedef struct packed {
  logic              expired;
  logic [MSEC_W-1:0] remaining;
  logic              bad;
} timer_result_t;

// Timeout timer predictor and queue of expected results
class timeout_scoreboard;
  logic [TPM_W-1:0]  tpm;
  logic              hw_mode;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] limit_ticks;
  logic [SMP_W-1:0]  last_smp;
  logic              expired;
  timer_result_t     expq[$];
  int                errors;

  function new();
    errors = 0;
    clear();
  endfunction

  // Match the state the block comes out of reset with
  function void clear();
    tpm         = TPM_RST;
    hw_mode     = 1'b1;
    elapsed     = '0;
    limit_ticks = '0;
    last_smp    = '0;
    expired     = 1'b1;
    expq.delete();
  endfunction

  function void write_reg(cfg_idx_t idx, logic [TPM_W-1:0] v);
    if (idx == CFG_TPM) tpm = v;
    else hw_mode = v[0];
  endfunction

  function int pending();
    return expq.size();
  endfunction

  // Advance the timer state for one accepted command and queue its result
  function void note_command(op_t op, logic [MSEC_W-1:0] ms, logic [SMP_W-1:0] smp);
    timer_result_t     res;
    logic [SMP_W-1:0]  fresh;
    logic [SMP_W-1:0]  delta;
    logic [TICK_W-1:0] sum;
    logic [TICK_W-1:0] left;
    logic [TICK_W-1:0] quo;
    res = '0;
    case (op)
      OP_START: begin
        limit_ticks = {{(TICK_W-MSEC_W){1'b0}}, ms} * {{(TICK_W-TPM_W){1'b0}}, tpm};
        elapsed     = '0;
        expired     = 1'b0;
        last_smp    = hw_mode ? smp : '0;
      end
      OP_POLL: begin
        if (!expired) begin
          fresh = hw_mode ? smp : last_smp + 1'b1;
          delta = fresh - last_smp;
          sum   = elapsed + {{(TICK_W-SMP_W){1'b0}}, delta};
          // expiry keeps the old count and sample
          if (sum >= limit_ticks) begin
            expired = 1'b1;
          end else begin
            last_smp = fresh;
            elapsed  = sum;
          end
        end
      end
      OP_QUERY: begin
        if (!expired) begin
          left = (limit_ticks >= elapsed) ? limit_ticks - elapsed : '0;
          if (left == '0) begin
            res.remaining = '0;
          end else if (tpm == '0) begin
            res.remaining = MSEC_MAX;
          end else begin
            quo = left / {{(TICK_W-TPM_W){1'b0}}, tpm};
            // saturate when the rate was lowered after start
            res.remaining = (quo > {{(TICK_W-MSEC_W){1'b0}}, MSEC_MAX}) ?
                            MSEC_MAX : quo[MSEC_W-1:0];
          end
        end
      end
      default: res.bad = 1'b1;
    endcase
    res.expired = expired;
    expq.push_back(res);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Compare one result transfer against the oldest expectation
  task check_result(logic got_exp, logic [MSEC_W-1:0] got_rem, logic got_bad);
    timer_result_t want;
    if (expq.size() == 0) begin
      report_mismatch("result transfer with no command outstanding");
    end else begin
      want = expq.pop_front();
      if (got_exp !== want.expired)
        report_mismatch($sformatf("expired got %0b want %0b", got_exp, want.expired));
      if (got_rem !== want.remaining)
        report_mismatch($sformatf("remaining_msec got %0d want %0d",
                                  got_rem, want.remaining));
      if (got_bad !== want.bad)
        report_mismatch($sformatf("bad_opcode got %0b want %0b", got_bad, want.bad));
    end
  endtask
endclass

module tb_top;
  localparam int IDLE_LIMIT   = 5000;
  localparam int END_PAUSE    = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 205;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [TPM_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_opcode;
  logic [MSEC_W-1:0] in_msec;
  logic [SMP_W-1:0]  in_timer_sample;
  logic              out_valid;
  logic              out_ready;
  logic              out_expired;
  logic [MSEC_W-1:0] out_remaining_msec;
  logic              out_bad_opcode;

  timeout_scoreboard sb;
  logic [SMP_W-1:0]  cur_smp;
  bit                calm;
  int                idle_cycles;
  int                out_hold;

  elapsed_timeout_timer_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_msec            (in_msec),
    .in_timer_sample    (in_timer_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_expired        (out_expired),
    .out_remaining_msec (out_remaining_msec),
    .out_bad_opcode     (out_bad_opcode)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_expired, out_remaining_msec, out_bad_opcode);
  end

  // Stall the result side at random
  initial begin
    out_hold = 0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
    end
  end

  // Drop the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one command, hold it until the transfer, then idle for a random gap, if any
  task automatic send_cmd(op_t op, logic [MSEC_W-1:0] ms, logic [SMP_W-1:0] smp);
    int gap;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_msec         <= ms;
    in_timer_sample <= smp;
    do @(posedge clk); while (!in_ready);
    sb.note_command(op, ms, smp);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [TPM_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Sample step scaled to the rate so timeouts run out in a few polls
  function automatic logic [SMP_W-1:0] step_max();
    if (sb.tpm == '0 || sb.tpm > 32'h3fff_ffff) return '1;
    return sb.tpm * 3;
  endfunction

  function automatic logic [MSEC_W-1:0] pick_msec();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return MSEC_W'($urandom);
    if (r < 6) return MSEC_MAX;
    if (sb.hw_mode) return MSEC_W'($urandom_range(0, 6));
    if (sb.tpm == '0 || sb.tpm > 20) return MSEC_W'($urandom_range(0, 1));
    return MSEC_W'($urandom_range(0, 20 / sb.tpm));
  endfunction

  // One random command: mostly start/poll/query runs on an advancing counter
  task automatic random_item();
    int                r;
    op_t               op;
    logic [MSEC_W-1:0] ms;
    logic [SMP_W-1:0]  smp;
    r   = $urandom_range(0, 99);
    smp = cur_smp + SMP_W'($urandom_range(0, step_max()));
    if ($urandom_range(0, 19) == 0) smp = $urandom;
    ms = MSEC_W'($urandom);
    if (r < 14) begin
      op = OP_START;
      ms = pick_msec();
    end else if (r < 64) begin
      op = OP_POLL;
    end else if (r < 92) begin
      op = OP_QUERY;
    end else begin
      op = OP_BAD;
    end
    cur_smp = smp;
    send_cmd(op, ms, smp);
    if ($urandom_range(0, 149) == 0) wait_drain();
  endtask

  initial begin
    logic [TPM_W-1:0] tpm_set[PHASES];
    logic             hw_set[PHASES];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TPM;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_opcode       = OP_START;
    in_msec         = '0;
    in_timer_sample = '0;
    out_ready       = 1'b0;
    idle_cycles     = 0;
    cur_smp         = '0;
    calm            = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Expired out of reset, poll while expired, invalid code
    send_cmd(OP_QUERY, '0, '0);
    send_cmd(OP_POLL, '0, 32'd5);
    send_cmd(OP_BAD, MSEC_MAX, '1);
    // Zero timeout: query reads 0 unexpired, first poll expires
    send_cmd(OP_START, '0, 32'hffff_fff0);
    send_cmd(OP_QUERY, '0, '0);
    send_cmd(OP_POLL, '0, 32'hffff_fff0);
    // Longest timeout with a counter wrap
    send_cmd(OP_START, MSEC_MAX, 32'hffff_ff00);
    send_cmd(OP_POLL, '0, 32'h0000_0100);
    send_cmd(OP_QUERY, '0, '0);
    send_cmd(OP_BAD, '0, '0);
    // Lower the rate after start so the quotient saturates
    wait_drain();
    write_reg(CFG_TPM, 32'd1);
    send_cmd(OP_QUERY, '0, '0);
    // Zero rate with ticks left, then a zero-length timeout
    wait_drain();
    write_reg(CFG_TPM, '0);
    send_cmd(OP_QUERY, '0, '0);
    send_cmd(OP_START, 31'd5, 32'h1234_5678);
    send_cmd(OP_QUERY, '0, '0);
    // Loop mode: one tick per poll, sample ignored
    wait_drain();
    write_reg(CFG_TPM, 32'd2);
    write_reg(CFG_HW, 32'd0);
    send_cmd(OP_START, 31'd2, 32'hdead_beef);
    repeat (4) send_cmd(OP_POLL, '0, $urandom);
    send_cmd(OP_QUERY, '0, '0);
    // Widest rate, full-range delta reaches the timeout exactly
    wait_drain();
    write_reg(CFG_HW, 32'd1);
    write_reg(CFG_TPM, '1);
    send_cmd(OP_START, 31'd1, '0);
    send_cmd(OP_POLL, '0, '1);
    wait_drain();

    tpm_set = '{32'd1000, 32'd1, 32'd3, 32'hffff_ffff,
                32'($urandom_range(1, 12)), 32'd0, 32'($urandom), 32'd1};
    hw_set  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_TPM, tpm_set[p]);
      write_reg(CFG_HW, {31'd0, hw_set[p]});
      calm = (p == 2 || p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      wait_drain();
    end
    calm = 1'b0;

    // Catch stray results after the last expectation
    repeat (END_PAUSE) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
